/* design/rsc_pkg.sv */
// Package for the rolling / single-shot capture buffer: sizes, codes and the
// store control type shared by the top level, the sample store and the checker.
// Depends on nothing.
`default_nettype none

package rsc_pkg;

  // Buffer geometry
  localparam int SAMPLES      = 1024;
  localparam int CHANNELS     = 4;
  localparam int VALUE_INPUTS = 4;
  localparam int LANES        = (CHANNELS < VALUE_INPUTS) ? CHANNELS : VALUE_INPUTS;
  localparam int ADDR_W       = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int COUNT_W      = $clog2(SAMPLES + 1);
  localparam int LANE_W       = (LANES > 1) ? $clog2(LANES) : 1;

  // Field widths
  localparam int DATA_W      = 32;
  localparam int INTERVAL_W  = 31;
  localparam int CCOUNT_W    = 3;
  localparam int MASK_W      = 4;
  localparam int OUT_COUNT_W = 11;
  localparam int RIDX_W      = 10;
  localparam int RCH_W       = 2;
  localparam int ACTION_W    = 2;
  localparam int CFG_ADDR_W  = 2;

  // Q16.16 window of 4.0 spread over the buffer; used for a zero interval
  localparam logic [DATA_W-1:0]     WINDOW_DEFAULT   = 32'd262144;
  localparam logic [DATA_W-1:0]     DEFAULT_INTERVAL = DATA_W'(WINDOW_DEFAULT / SAMPLES);
  localparam logic [INTERVAL_W-1:0] RESET_INTERVAL   = 31'd256;
  localparam logic [MASK_W-1:0]     RESET_MASK       = 4'hF;

  // Item actions
  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ARM   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CCOUNT   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MASK     = 2'd3;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] wr_slot;
    logic [LANES-1:0]  lane_we;
    logic              re;
    logic [ADDR_W-1:0] rd_slot;
  } store_ctl_t;

  // Fold a pointer sum that stays below twice the depth back into the ring
  function automatic logic [ADDR_W-1:0] ring_wrap(input logic [ADDR_W:0] s);
    logic [ADDR_W:0] r;
    r = (s >= (ADDR_W+1)'(SAMPLES)) ? s - (ADDR_W+1)'(SAMPLES) : s;
    return r[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/rolling_or_single_shot_capture_top.sv */
// Top level of the rolling / single-shot capture buffer: state update, ring
// pointers, result pipeline and configuration registers.
// Depends on rsc_pkg and rsc_store.
`default_nettype none

// Multi-channel trace capture ring. Each input transaction carries an action:
// tick (add a positive Q16.16 step to the interval accumulator and, once it
// reaches sample_interval, record the stamp and the active channel values),
// arm (empty the buffer and start recording), clear (empty the buffer; stay
// armed only in rolling mode) or read (return one stored sample, entry 0 the
// oldest, zero when out of range). Rolling mode overwrites the oldest entry
// once SAMPLES entries are held; triggered mode drops the first sample that
// finds the buffer full, raises full and disarms. Every input transaction
// gives exactly one result transaction. The block takes one transaction per
// clock while in_stall is low; a result passes the registered read port of
// the sample memories and then the output register.
// The result register and the stage in front of it hold while
// out_stall is high, and in_stall rises only when both are occupied.
// Configuration writes are always ready (cfg_ready is tied high); writing
// capture_mode or channel_count empties the buffer. The memories are not
// cleared after reset: reads are gated by the stored count, so no clearing
// pass is needed and the block takes transactions right out of reset.
module rolling_or_single_shot_capture_top
  import rsc_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input transactions
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ACTION_W-1:0]          in_action,
  input  wire logic signed [DATA_W-1:0]     in_step_time,
  input  wire logic signed [DATA_W-1:0]     in_time_stamp,
  input  wire logic signed [DATA_W-1:0]     in_value_ch0,
  input  wire logic signed [DATA_W-1:0]     in_value_ch1,
  input  wire logic signed [DATA_W-1:0]     in_value_ch2,
  input  wire logic signed [DATA_W-1:0]     in_value_ch3,
  input  wire logic [RCH_W-1:0]             in_read_channel,
  input  wire logic [RIDX_W-1:0]            in_read_index,
  // result transactions
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_W-1:0]          out_read_value,
  output logic signed [DATA_W-1:0]          out_read_time,
  output logic [OUT_COUNT_W-1:0]            out_sample_count,
  output logic                              out_armed_flag,
  output logic                              out_full_flag,
  output logic                              out_sampled,
  // configuration writes
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  wire logic [DATA_W-1:0]            cfg_wdata
);

  // Configuration registers
  logic                  mode_r,     mode_nxt;
  logic [INTERVAL_W-1:0] interval_r, interval_nxt;
  logic [CCOUNT_W-1:0]   ccount_r,   ccount_nxt;
  logic [MASK_W-1:0]     mask_r,     mask_nxt;

  // Capture state
  logic [ADDR_W-1:0]  oldest_r, oldest_nxt;
  logic [COUNT_W-1:0] count_r,  count_nxt;
  logic [DATA_W-1:0]  since_r,  since_nxt;
  logic               armed_r,  armed_nxt;
  logic               full_r,   full_nxt;

  // Stage between accept and output: metadata beside the memory read data
  logic               s1_v_r, s1_v_nxt;
  logic               s1_rd_hit_r, s1_ch_hit_r;
  logic [LANE_W-1:0]  s1_lane_r;
  logic [COUNT_W-1:0] s1_count_r;
  logic               s1_armed_r, s1_full_r, s1_did_r;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]        out_value_r, out_time_r;
  logic [OUT_COUNT_W-1:0]   out_count_r;
  logic                     out_armed_r, out_full_r, out_did_r;

  logic in_accept, cfg_we, move;
  logic did, rd_hit, ch_hit;
  logic [LANE_W-1:0] rd_lane;

  logic [CCOUNT_W-1:0] n_eff;
  logic [DATA_W-1:0]   eff_int;
  logic [DATA_W:0]     acc_sum;
  logic [DATA_W-1:0]   acc_sat;
  logic                step_pos;

  store_ctl_t                  ctl;
  logic [VALUE_INPUTS-1:0][DATA_W-1:0] in_vals;
  logic [LANES-1:0][DATA_W-1:0] wr_lanes;
  logic [DATA_W-1:0]            rd_stamp;
  logic [LANES-1:0][DATA_W-1:0] rd_lanes;

  // Handshakes: the middle stage drains whenever the output register is free
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign move      = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_v_r && out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign s1_v_nxt      = in_accept || (s1_v_r && !move);
  assign out_valid_nxt = move || (out_valid_r && out_stall);

  // Effective channel count and interval
  assign n_eff   = (32'(ccount_r) > LANES) ? CCOUNT_W'(LANES) : ccount_r;
  assign eff_int = (interval_r == '0) ? DEFAULT_INTERVAL : {1'b0, interval_r};

  // Saturating accumulator
  assign step_pos = (in_step_time != '0) && !in_step_time[DATA_W-1];
  assign acc_sum  = {1'b0, since_r} + {1'b0, in_step_time};
  assign acc_sat  = acc_sum[DATA_W] ? '1 : acc_sum[DATA_W-1:0];

  assign in_vals = {in_value_ch3, in_value_ch2, in_value_ch1, in_value_ch0};

  // Drop values of channels that were not found
  always_comb begin
    for (int g = 0; g < LANES; g++) begin
      wr_lanes[g] = mask_r[g] ? in_vals[g] : '0;
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    interval_nxt = interval_r;
    ccount_nxt   = ccount_r;
    mask_nxt     = mask_r;
    oldest_nxt   = oldest_r;
    count_nxt    = count_r;
    since_nxt    = since_r;
    armed_nxt    = armed_r;
    full_nxt     = full_r;
    ctl          = '0;
    did          = 1'b0;
    rd_hit       = 1'b0;
    ch_hit       = 1'b0;
    rd_lane      = LANE_W'(in_read_channel);

    if (cfg_we) begin
      case (cfg_addr)
        REG_MODE: begin
          mode_nxt   = cfg_wdata[0];
          oldest_nxt = '0;
          count_nxt  = '0;
          since_nxt  = eff_int;
          full_nxt   = 1'b0;
          armed_nxt  = !cfg_wdata[0];
        end
        REG_INTERVAL: begin
          interval_nxt = cfg_wdata[INTERVAL_W-1:0];
        end
        REG_CCOUNT: begin
          ccount_nxt = cfg_wdata[CCOUNT_W-1:0];
          oldest_nxt = '0;
          count_nxt  = '0;
          since_nxt  = eff_int;
          full_nxt   = 1'b0;
          armed_nxt  = !mode_r;
        end
        REG_MASK: begin
          mask_nxt = cfg_wdata[MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (in_accept) begin
      case (in_action)
        ACT_TICK: begin
          if ((n_eff != '0) && step_pos && armed_r) begin
            since_nxt = acc_sat;
            if (acc_sat >= eff_int) begin
              since_nxt = '0;
              if (count_r < COUNT_W'(SAMPLES)) begin
                // still filling: append behind the newest entry
                ctl.we      = 1'b1;
                ctl.wr_slot = ring_wrap((ADDR_W+1)'(oldest_r) + (ADDR_W+1)'(count_r));
                count_nxt   = count_r + 1'b1;
                did         = 1'b1;
              end else if (!mode_r) begin
                // rolling: overwrite the oldest and advance past it
                ctl.we      = 1'b1;
                ctl.wr_slot = oldest_r;
                oldest_nxt  = ring_wrap((ADDR_W+1)'(oldest_r) + 1'b1);
                did         = 1'b1;
              end else begin
                // single shot: drop the sample, stop capture
                full_nxt  = 1'b1;
                armed_nxt = 1'b0;
              end
            end
          end
        end
        ACT_ARM: begin
          oldest_nxt = '0;
          count_nxt  = '0;
          since_nxt  = eff_int;
          full_nxt   = 1'b0;
          armed_nxt  = 1'b1;
        end
        ACT_CLEAR: begin
          oldest_nxt = '0;
          count_nxt  = '0;
          since_nxt  = eff_int;
          full_nxt   = 1'b0;
          armed_nxt  = !mode_r;
        end
        ACT_READ: begin
          rd_hit      = 32'(in_read_index) < 32'(count_r);
          ch_hit      = 32'(in_read_channel) < 32'(n_eff);
          ctl.re      = 1'b1;
          ctl.rd_slot = ring_wrap((ADDR_W+1)'(oldest_r) + (ADDR_W+1)'(in_read_index));
        end
        default: begin
        end
      endcase
    end

    for (int g = 0; g < LANES; g++) begin
      ctl.lane_we[g] = 32'(n_eff) > g;
    end
  end

  rsc_store u_store (
    .clk      (clk),
    .ctl      (ctl),
    .wr_stamp (in_time_stamp),
    .wr_lanes (wr_lanes),
    .rd_stamp (rd_stamp),
    .rd_lanes (rd_lanes)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      interval_r  <= RESET_INTERVAL;
      ccount_r    <= '0;
      mask_r      <= RESET_MASK;
      oldest_r    <= '0;
      count_r     <= '0;
      since_r     <= {1'b0, RESET_INTERVAL};
      armed_r     <= 1'b1;
      full_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      interval_r  <= interval_nxt;
      ccount_r    <= ccount_nxt;
      mask_r      <= mask_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      since_r     <= since_nxt;
      armed_r     <= armed_nxt;
      full_r      <= full_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Metadata travels beside the memory read; hold it while the stage waits
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_rd_hit_r <= rd_hit;
      s1_ch_hit_r <= ch_hit;
      s1_lane_r   <= rd_lane;
      s1_count_r  <= count_nxt;
      s1_armed_r  <= armed_nxt;
      s1_full_r   <= full_nxt;
      s1_did_r    <= did;
    end
  end

  // Output register: pick the lane and zero anything out of range
  always_ff @(posedge clk) begin
    if (move) begin
      out_value_r <= (s1_rd_hit_r && s1_ch_hit_r) ? rd_lanes[s1_lane_r] : '0;
      out_time_r  <= s1_rd_hit_r ? rd_stamp : '0;
      out_count_r <= OUT_COUNT_W'(s1_count_r);
      out_armed_r <= s1_armed_r;
      out_full_r  <= s1_full_r;
      out_did_r   <= s1_did_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_value_r;
  assign out_read_time    = out_time_r;
  assign out_sample_count = out_count_r;
  assign out_armed_flag   = out_armed_r;
  assign out_full_flag    = out_full_r;
  assign out_sampled      = out_did_r;

endmodule

`default_nettype wire

/* design/rsc_store.sv */
// Sample store: one time stamp memory and one value memory per channel lane,
// each with one write port and one registered read port.
// Depends on rsc_pkg.
`default_nettype none

module rsc_store
  import rsc_pkg::*;
(
  input  wire logic                         clk,
  input  wire store_ctl_t                   ctl,
  input  wire logic [DATA_W-1:0]            wr_stamp,
  input  wire logic [LANES-1:0][DATA_W-1:0] wr_lanes,
  output logic [DATA_W-1:0]                 rd_stamp,
  output logic [LANES-1:0][DATA_W-1:0]      rd_lanes
);

  logic [DATA_W-1:0] stamp_mem [SAMPLES];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      stamp_mem[ctl.wr_slot] <= wr_stamp;
    end
    if (ctl.re) begin
      rd_stamp <= stamp_mem[ctl.rd_slot];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [DATA_W-1:0] lane_mem [SAMPLES];

    always_ff @(posedge clk) begin
      if (ctl.we && ctl.lane_we[g]) begin
        lane_mem[ctl.wr_slot] <= wr_lanes[g];
      end
      if (ctl.re) begin
        rd_lanes[g] <= lane_mem[ctl.rd_slot];
      end
    end
  end

endmodule

`default_nettype wire

/* design/rsc_checker.sv */
// Port-level checker for the capture buffer top level, attached by bind.
// Depends on rsc_pkg and rolling_or_single_shot_capture_top.
`default_nettype none

module rsc_checker
  import rsc_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_stall,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic signed [DATA_W-1:0] out_read_value,
  input wire logic signed [DATA_W-1:0] out_read_time,
  input wire logic [OUT_COUNT_W-1:0]   out_sample_count,
  input wire logic                     out_armed_flag,
  input wire logic                     out_full_flag,
  input wire logic                     out_sampled
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value)
      && $stable(out_read_time) && $stable(out_sample_count))
    else $error("stalled result transaction changed");

  // Input backpressure only when the result side is full and stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side can drain");

  // A recorded sample never comes from a stopped capture
  a_sampled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sampled |-> out_armed_flag && !out_full_flag)
    else $error("sample recorded while disarmed or full");

  // Full means single shot has stopped
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_flag |-> !out_armed_flag)
    else $error("full and armed at once");

  // Stored count never passes the depth
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_sample_count) <= 32'(SAMPLES))
    else $error("sample count beyond buffer depth");

endmodule

bind rolling_or_single_shot_capture_top rsc_checker u_rsc_checker (.*);

`default_nettype wire
